### hw/rtl/bcpe_pkg.sv
// ----------------------------------------------------------------------------
// bcpe_pkg: shared types and constants of the boot command packet engine
// Holds command codes, register indexes, LED modes, reply kinds and name ROMs.
// ----------------------------------------------------------------------------
`default_nettype none
package bcpe_pkg;

    // Command codes.
    localparam logic [7:0] CMD_ACTIVATE   = 8'h02;
    localparam logic [7:0] CMD_DEACTIVATE = 8'h03;
    localparam logic [7:0] CMD_VERSION    = 8'h04;
    localparam logic [7:0] CMD_DEV_NAME   = 8'h10;
    localparam logic [7:0] CMD_MOD_NAME   = 8'h11;
    localparam logic [7:0] CMD_BOOT_SIZE  = 8'h20;
    localparam logic [7:0] CMD_FLASH_SIZE = 8'h21;
    localparam logic [7:0] CMD_PAGE_SIZE  = 8'h22;
    localparam logic [7:0] CMD_SET_PAGE   = 8'h30;

    // Commands below this code are allowed while inactive.
    localparam logic [7:0] CMD_OPEN_LIMIT = 8'h03;

    // Register indexes.
    localparam logic [2:0] REG_START_BYTE = 3'd0;
    localparam logic [2:0] REG_ERR_REPLY  = 3'd1;
    localparam logic [2:0] REG_VERSION    = 3'd2;
    localparam logic [2:0] REG_BOOT_TO    = 3'd3;
    localparam logic [2:0] REG_IDLE_TO    = 3'd4;
    localparam logic [2:0] REG_BLINK      = 3'd5;
    localparam logic [2:0] REG_FLASH_ON   = 3'd6;
    localparam logic [2:0] REG_FLASH_OFF  = 3'd7;

    // Header length in bytes: start, command, length high, length low.
    localparam logic [4:0] HDR_LEN = 5'd4;

    typedef enum logic [1:0] {
        LED_BLINK     = 2'd0,
        LED_FLASH_ON  = 2'd1,
        LED_FLASH_OFF = 2'd2
    } t_led_mode;

    typedef enum logic [2:0] {
        RPL_PLAIN = 3'd0,
        RPL_VER   = 3'd1,
        RPL_DEV   = 3'd2,
        RPL_MOD   = 3'd3,
        RPL_SIZE  = 3'd4
    } t_reply;

    typedef struct packed {
        logic [7:0]  start_byte;
        logic [7:0]  err_reply;
        logic [7:0]  version;
        logic [15:0] boot_to;
        logic [15:0] idle_to;
        logic [15:0] blink;
        logic [15:0] flash_on;
        logic [15:0] flash_off;
    } t_cfg;

    // Controller to datapath.
    typedef struct packed {
        logic       step;
        logic       advance;
        logic [4:0] idx;
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic last;
    } t_dp_sts;

    localparam logic [7:0] DEV_NAME_ROM [16] = '{
        8'h44, 8'h45, 8'h56, 8'h49, 8'h43, 8'h45, 8'h30, 8'h31,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };
    localparam logic [7:0] MOD_NAME_ROM [16] = '{
        8'h4D, 8'h4F, 8'h44, 8'h55, 8'h4C, 8'h45, 8'h30, 8'h31,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

endpackage
`default_nettype wire

### hw/rtl/bcpe_ctrl.sv
// ----------------------------------------------------------------------------
// bcpe_ctrl: sequencer of the boot command packet engine
// Takes one input word, then walks the reply words out one at a time.
// ----------------------------------------------------------------------------
`default_nettype none
module bcpe_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    output logic             o_valid,
    input  wire              i_ready,
    input  bcpe_pkg::t_dp_sts i_sts,
    output bcpe_pkg::t_dp_cmd o_cmd
);
    import bcpe_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } t_state;

    t_state     r_state, n_state;
    logic [4:0] r_idx, n_idx;

    // Next state and word index.
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_EMIT;
                    n_idx   = '0;
                end
            end
            ST_EMIT: begin
                if (i_ready) begin
                    if (i_sts.last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx + 5'd1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    assign o_ready     = (r_state == ST_IDLE);
    assign o_valid     = (r_state == ST_EMIT);
    assign o_cmd.step  = o_ready && i_valid;
    assign o_cmd.advance = o_valid && i_ready;
    assign o_cmd.idx   = r_idx;

endmodule
`default_nettype wire

### hw/rtl/bcpe_dp.sv
// ----------------------------------------------------------------------------
// bcpe_dp: datapath of the boot command packet engine
// Holds framing, LED, timeout and page state and builds the reply words.
// ----------------------------------------------------------------------------
`default_nettype none
module bcpe_dp #(
    parameter int PAGE_BYTES       = 128,
    parameter int FLASH_SIZE_VALUE = 32,
    parameter int BOOT_SIZE_VALUE  = 2048,
    parameter int NAME_MAX         = 16,
    parameter int DEVICE_NAME_LEN  = 8,
    parameter int MODULE_NAME_LEN  = 8
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  bcpe_pkg::t_cfg    i_cfg,
    input  bcpe_pkg::t_dp_cmd i_cmd,
    output bcpe_pkg::t_dp_sts o_sts,
    input  wire               i_func,
    input  wire               i_tick,
    input  wire [7:0]         i_rx_byte,
    output logic              o_resp_valid,
    output logic [7:0]        o_resp_byte,
    output logic              o_resp_last,
    output logic              o_led_on,
    output logic              o_start_app,
    output logic [31:0]       o_page_address
);
    import bcpe_pkg::*;

    // Name lengths clamped to the limit and to the table depth.
    localparam int DEV_CL = (DEVICE_NAME_LEN > NAME_MAX) ? NAME_MAX : DEVICE_NAME_LEN;
    localparam int MOD_CL = (MODULE_NAME_LEN > NAME_MAX) ? NAME_MAX : MODULE_NAME_LEN;
    localparam logic [4:0] DEV_N = 5'((DEV_CL > 16) ? 16 : DEV_CL);
    localparam logic [4:0] MOD_N = 5'((MOD_CL > 16) ? 16 : MOD_CL);
    localparam logic [15:0] BOOT_SZ  = 16'(BOOT_SIZE_VALUE);
    localparam logic [15:0] FLASH_SZ = 16'(FLASH_SIZE_VALUE);
    localparam logic [15:0] PAGE_SZ  = 16'(PAGE_BYTES);

    logic [15:0] r_count, n_count;
    logic [7:0]  r_hdr [3];
    logic [7:0]  n_hdr [3];
    logic [7:0]  r_pay [4];
    logic [7:0]  n_pay [4];
    logic        r_active, n_active;
    t_led_mode   r_mode, n_mode;
    logic        r_level, n_level;
    logic [15:0] r_led_t, n_led_t;
    logic [15:0] r_boot_t, n_boot_t;
    logic [15:0] r_idle_t, n_idle_t;
    logic [31:0] r_page, n_page;
    logic        r_halted, n_halted;
    logic        r_has_tx, n_has_tx;
    logic [4:0]  r_plen, n_plen;
    t_reply      r_kind, n_kind;
    logic [7:0]  r_code, n_code;
    logic [15:0] r_size, n_size;

    logic [16:0] w_target;
    logic        w_stop;
    logic [7:0]  w_cmd;
    logic        w_ok;

    // One poll: tick handling, byte framing and command dispatch.
    always_comb begin
        n_count  = r_count;
        n_hdr    = r_hdr;
        n_pay    = r_pay;
        n_active = r_active;
        n_mode   = r_mode;
        n_level  = r_level;
        n_led_t  = r_led_t;
        n_boot_t = r_boot_t;
        n_idle_t = r_idle_t;
        n_page   = r_page;
        n_halted = r_halted;
        n_has_tx = 1'b0;
        n_plen   = '0;
        n_kind   = RPL_PLAIN;
        n_code   = r_code;
        n_size   = r_size;
        w_stop   = r_halted;
        w_target = '0;
        w_cmd    = '0;
        w_ok     = 1'b0;

        // Timer tick: counters, boot timeout and LED pattern.
        if (!r_halted && i_tick) begin
            n_led_t  = r_led_t + 16'd1;
            n_idle_t = r_idle_t + 16'd1;
            if (r_active) begin
                n_boot_t = '0;
            end else begin
                n_boot_t = r_boot_t + 16'd1;
                if (n_boot_t >= i_cfg.boot_to) begin
                    n_level  = 1'b0;
                    n_halted = 1'b1;
                    w_stop   = 1'b1;
                end
            end
            if (!w_stop) begin
                if (n_mode == LED_BLINK && n_led_t == i_cfg.blink) begin
                    n_led_t = '0;
                    n_level = ~n_level;
                end
                if (n_mode == LED_FLASH_ON && n_led_t == i_cfg.flash_on) begin
                    n_mode  = LED_FLASH_OFF;
                    n_level = 1'b0;
                    n_led_t = '0;
                end
                if (n_mode == LED_FLASH_OFF && n_led_t == i_cfg.flash_off) begin
                    n_mode  = LED_FLASH_ON;
                    n_level = 1'b1;
                    n_led_t = '0;
                end
            end
        end

        // Received byte or idle timeout.
        if (!w_stop) begin
            if (i_func) begin
                if (r_count != 16'd0 || i_rx_byte == i_cfg.start_byte) begin
                    n_idle_t = '0;
                    if (r_count >= 16'd1 && r_count <= 16'd3) begin
                        n_hdr[r_count[1:0] - 2'd1] = i_rx_byte;
                    end else if (r_count >= 16'd4 && r_count <= 16'd7) begin
                        n_pay[r_count[1:0]] = i_rx_byte;
                    end
                    if (r_count != 16'hFFFF) begin
                        n_count = r_count + 16'd1;
                    end
                    w_target = {1'b0, n_hdr[1], n_hdr[2]} + 17'd4;
                    if (n_count >= 16'd4 && {1'b0, n_count} == w_target) begin
                        w_cmd = n_hdr[0];
                        if (w_cmd < CMD_OPEN_LIMIT || r_active) begin
                            w_ok = 1'b1;
                            unique case (w_cmd)
                                CMD_ACTIVATE: begin
                                    n_mode   = LED_FLASH_ON;
                                    n_led_t  = '0;
                                    n_active = 1'b1;
                                end
                                CMD_DEACTIVATE: begin
                                    n_mode   = LED_BLINK;
                                    n_led_t  = '0;
                                    n_active = 1'b0;
                                end
                                CMD_VERSION: begin
                                    n_kind = RPL_VER;
                                    n_plen = 5'd1;
                                end
                                CMD_DEV_NAME: begin
                                    n_kind = RPL_DEV;
                                    n_plen = DEV_N;
                                end
                                CMD_MOD_NAME: begin
                                    n_kind = RPL_MOD;
                                    n_plen = MOD_N;
                                end
                                CMD_BOOT_SIZE: begin
                                    n_kind = RPL_SIZE;
                                    n_plen = 5'd2;
                                    n_size = BOOT_SZ;
                                end
                                CMD_FLASH_SIZE: begin
                                    n_kind = RPL_SIZE;
                                    n_plen = 5'd2;
                                    n_size = FLASH_SZ;
                                end
                                CMD_PAGE_SIZE: begin
                                    n_kind = RPL_SIZE;
                                    n_plen = 5'd2;
                                    n_size = PAGE_SZ;
                                end
                                CMD_SET_PAGE: begin
                                    n_page = {n_pay[0], n_pay[1], n_pay[2], n_pay[3]};
                                end
                                default: w_ok = 1'b0;
                            endcase
                        end
                        if (!w_ok) begin
                            n_plen = '0;
                            n_kind = RPL_PLAIN;
                        end
                        n_code   = w_ok ? ~w_cmd : i_cfg.err_reply;
                        n_has_tx = 1'b1;
                        n_count  = '0;
                        n_idle_t = '0;
                    end
                end
            end else if (n_idle_t >= i_cfg.idle_to) begin
                n_count  = '0;
                n_idle_t = '0;
            end
        end
    end

    // State update, taken when a word is accepted.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_hdr    <= '{default: '0};
            r_pay    <= '{default: '0};
            r_active <= 1'b0;
            r_mode   <= LED_BLINK;
            r_level  <= 1'b1;
            r_led_t  <= '0;
            r_boot_t <= '0;
            r_idle_t <= '0;
            r_page   <= '0;
            r_halted <= 1'b0;
            r_has_tx <= 1'b0;
            r_plen   <= '0;
        end else if (i_cmd.step) begin
            r_count  <= n_count;
            r_hdr    <= n_hdr;
            r_pay    <= n_pay;
            r_active <= n_active;
            r_mode   <= n_mode;
            r_level  <= n_level;
            r_led_t  <= n_led_t;
            r_boot_t <= n_boot_t;
            r_idle_t <= n_idle_t;
            r_page   <= n_page;
            r_halted <= n_halted;
            r_has_tx <= n_has_tx;
            r_plen   <= n_plen;
        end
    end

    // Reply descriptor, payload only.
    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_kind <= n_kind;
            r_code <= n_code;
            r_size <= n_size;
        end
    end

    // Reply word selected by the controller's index.
    logic [4:0] w_p;
    logic [7:0] w_byte;
    always_comb begin
        w_p    = i_cmd.idx - HDR_LEN;
        w_byte = '0;
        if (i_cmd.idx == 5'd0) begin
            w_byte = i_cfg.start_byte;
        end else if (i_cmd.idx == 5'd1) begin
            w_byte = r_code;
        end else if (i_cmd.idx == 5'd2) begin
            w_byte = '0;
        end else if (i_cmd.idx == 5'd3) begin
            w_byte = {3'b000, r_plen};
        end else begin
            unique case (r_kind)
                RPL_VER:  w_byte = i_cfg.version;
                RPL_DEV:  w_byte = DEV_NAME_ROM[w_p[3:0]];
                RPL_MOD:  w_byte = MOD_NAME_ROM[w_p[3:0]];
                RPL_SIZE: w_byte = (w_p == 5'd0) ? r_size[15:8] : r_size[7:0];
                default:  w_byte = '0;
            endcase
        end
    end

    assign o_sts.last     = !r_has_tx || (i_cmd.idx == r_plen + HDR_LEN - 5'd1);
    assign o_resp_valid   = r_has_tx;
    assign o_resp_byte    = r_has_tx ? w_byte : 8'h00;
    assign o_resp_last    = o_sts.last;
    assign o_led_on       = r_level;
    assign o_start_app    = r_halted;
    assign o_page_address = r_page;

endmodule
`default_nettype wire

### hw/rtl/boot_command_packet_engine.sv
// ----------------------------------------------------------------------------
// boot_command_packet_engine: serial boot monitor packet engine
// Frames host packets, dispatches commands and sends reply words.
// ----------------------------------------------------------------------------
//  Channel   Signals                      Moves
//  input     i_valid / o_ready            one poll word (func, tick, rx_byte)
//  output    o_valid / i_ready            one reply or status word
//  config    psel/penable/pwrite/paddr    register writes and reads
//
//  A poll word is taken while o_ready is high; its replies then leave at one
//  word per cycle while i_ready is high, 1 to 20 words per poll word.
//  The reply sequencer holds o_ready low until the last word is taken.
//  Reset is synchronous and active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none
module boot_command_packet_engine #(
    parameter int PAGE_BYTES       = 128,
    parameter int FLASH_SIZE_VALUE = 32,
    parameter int BOOT_SIZE_VALUE  = 2048,
    parameter int NAME_MAX         = 16,
    parameter int DEVICE_NAME_LEN  = 8,
    parameter int MODULE_NAME_LEN  = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [4:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire         i_func,
    input  wire         i_tick,
    input  wire  [7:0]  i_rx_byte,
    output logic        o_valid,
    input  wire         i_ready,
    output logic        o_resp_valid,
    output logic [7:0]  o_resp_byte,
    output logic        o_resp_last,
    output logic        o_led_on,
    output logic        o_start_app,
    output logic [31:0] o_page_address
);
    import bcpe_pkg::*;

    t_cfg    r_cfg;
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic [2:0] w_ridx;

    assign pready = 1'b1;
    assign w_ridx = paddr[4:2];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte <= 8'd0;
            r_cfg.err_reply  <= 8'd0;
            r_cfg.version    <= 8'd1;
            r_cfg.boot_to    <= 16'hFFFF;
            r_cfg.idle_to    <= 16'hFFFF;
            r_cfg.blink      <= 16'hFFFF;
            r_cfg.flash_on   <= 16'hFFFF;
            r_cfg.flash_off  <= 16'hFFFF;
        end else if (psel && penable && pwrite) begin
            unique case (w_ridx)
                REG_START_BYTE: r_cfg.start_byte <= pwdata[7:0];
                REG_ERR_REPLY:  r_cfg.err_reply  <= pwdata[7:0];
                REG_VERSION:    r_cfg.version    <= pwdata[7:0];
                REG_BOOT_TO:    r_cfg.boot_to    <= pwdata[15:0];
                REG_IDLE_TO:    r_cfg.idle_to    <= pwdata[15:0];
                REG_BLINK:      r_cfg.blink      <= pwdata[15:0];
                REG_FLASH_ON:   r_cfg.flash_on   <= pwdata[15:0];
                REG_FLASH_OFF:  r_cfg.flash_off  <= pwdata[15:0];
                default:        r_cfg.start_byte <= r_cfg.start_byte;
            endcase
        end
    end

    // Register read back.
    always_comb begin
        unique case (w_ridx)
            REG_START_BYTE: prdata = {24'd0, r_cfg.start_byte};
            REG_ERR_REPLY:  prdata = {24'd0, r_cfg.err_reply};
            REG_VERSION:    prdata = {24'd0, r_cfg.version};
            REG_BOOT_TO:    prdata = {16'd0, r_cfg.boot_to};
            REG_IDLE_TO:    prdata = {16'd0, r_cfg.idle_to};
            REG_BLINK:      prdata = {16'd0, r_cfg.blink};
            REG_FLASH_ON:   prdata = {16'd0, r_cfg.flash_on};
            REG_FLASH_OFF:  prdata = {16'd0, r_cfg.flash_off};
            default:        prdata = '0;
        endcase
    end

    // Controller.
    bcpe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // Datapath.
    bcpe_dp #(
        .PAGE_BYTES       (PAGE_BYTES),
        .FLASH_SIZE_VALUE (FLASH_SIZE_VALUE),
        .BOOT_SIZE_VALUE  (BOOT_SIZE_VALUE),
        .NAME_MAX         (NAME_MAX),
        .DEVICE_NAME_LEN  (DEVICE_NAME_LEN),
        .MODULE_NAME_LEN  (MODULE_NAME_LEN)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_func         (i_func),
        .i_tick         (i_tick),
        .i_rx_byte      (i_rx_byte),
        .o_resp_valid   (o_resp_valid),
        .o_resp_byte    (o_resp_byte),
        .o_resp_last    (o_resp_last),
        .o_led_on       (o_led_on),
        .o_start_app    (o_start_app),
        .o_page_address (o_page_address)
    );

endmodule
`default_nettype wire

### hw/rtl/bcpe_checker.sv
// ----------------------------------------------------------------------------
// bcpe_checker: port level checks of the boot command packet engine
// Watches handshakes and status outputs over time.
// ----------------------------------------------------------------------------
`default_nettype none
module bcpe_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_ready,
    input wire        o_valid,
    input wire        i_ready,
    input wire        o_resp_valid,
    input wire        o_resp_last,
    input wire [7:0]  o_resp_byte,
    input wire        o_led_on,
    input wire        o_start_app
);

    // A waiting output word holds its byte.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_resp_byte))
        else $error("output word changed while stalled");

    // No poll word is taken while replies are going out.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready))
        else $error("input ready while output valid");

    // A status word is always a single last word.
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_resp_valid |-> o_resp_last)
        else $error("status word not marked last");

    // Once halted, the LED is dark and the halt stays.
    a_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_start_app |=> o_start_app && !o_led_on)
        else $error("halt state left");

endmodule

bind boot_command_packet_engine bcpe_checker u_bcpe_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_resp_valid (o_resp_valid),
    .o_resp_last  (o_resp_last),
    .o_resp_byte  (o_resp_byte),
    .o_led_on     (o_led_on),
    .o_start_app  (o_start_app)
);
`default_nettype wire
